// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of aclk while aresetn is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that cond at one edge is followed by result at the next edge.
`define ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (result)) else $error(msg);

`endif

// ===== hdl/krhv_pkg.sv =====
// ----------------------------------------------------------------------------
// krhv_pkg
// Types and constants of the key region hit voter.
// ----------------------------------------------------------------------------
package krhv_pkg;

    localparam int COORD_W = 11;
    localparam int SPAN_W  = 12;
    localparam int HIT_W   = 17;
    localparam int VOTE_W  = 4;
    localparam int KEYS    = 4;
    localparam int PROD_W  = 24;

    localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

    localparam logic [7:0] SKIN_CR_LO = 8'd139;
    localparam logic [7:0] SKIN_CR_HI = 8'd161;
    localparam logic [7:0] SKIN_CB_LO = 8'd79;
    localparam logic [7:0] SKIN_CB_HI = 8'd121;

    localparam logic [SPAN_W-1:0] C_INSET = 12'd5;

    // Key order everywhere: C, D, E, G.
    localparam logic [1:0] KEY_C = 2'd0;
    localparam logic [1:0] KEY_D = 2'd1;
    localparam logic [1:0] KEY_E = 2'd2;
    localparam logic [1:0] KEY_G = 2'd3;

    // Area divisors that set each key's hit threshold.
    localparam logic [5:0] KEY_DIV [KEYS] = '{6'd20, 6'd20, 6'd45, 6'd17};

    typedef enum logic [2:0] {
        HIT_NONE = 3'd0,
        HIT_C    = 3'd1,
        HIT_D    = 3'd2,
        HIT_E    = 3'd3,
        HIT_G    = 3'd4
    } hit_code_t;

    typedef enum logic [2:0] {
        CFG_BAND_LEFT  = 3'd0,
        CFG_BAND_TOP   = 3'd1,
        CFG_KEY_WIDTH  = 3'd2,
        CFG_KEY_HEIGHT = 3'd3,
        CFG_DIFF_THR   = 3'd4,
        CFG_CONFIRM    = 3'd5
    } cfg_index_t;

endpackage

// ===== hdl/key_region_hit_voter.sv =====
// ----------------------------------------------------------------------------
// key_region_hit_voter
// Counts foreground pixels in four key rectangles and votes on a note.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel, one word per pixel, with s_tlast on the
// last pixel of a frame. Only that last pixel produces a word on the m_
// channel: the key hit in this frame and, once enough frame votes agree, a
// confirmed note. Other pixels produce no output word.
// The configuration port writes one register per cycle while cfg_we is high;
// the user is to make writes only while the block is idle; the block does
// not enforce this. A pixel passes an input register and a flag register
// before the counters and the result register. One pixel is accepted every
// cycle while s_tready is high; the rate is set by the single counter update
// stage.
// A synchronous active-low reset loads the register defaults and clears the
// hit counts, the votes and all valid flags.
// While the receiver stalls, pixels keep flowing; s_tready drops only when a
// frame-end word reaches the counter stage and the previous result word has
// not yet been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_region_hit_voter #(
    parameter int COORD_LIMIT = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_gray, background_gray, pixel_cr, pixel_cb, column, row, zero pad
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_key, note_valid, note_key, zero pad
    output logic [7:0]  m_tdata
);

    localparam int COORD_W = krhv_pkg::COORD_W;
    localparam int SPAN_W  = krhv_pkg::SPAN_W;
    localparam int HIT_W   = krhv_pkg::HIT_W;
    localparam int VOTE_W  = krhv_pkg::VOTE_W;
    localparam int KEYS    = krhv_pkg::KEYS;
    localparam int PROD_W  = krhv_pkg::PROD_W;
    localparam int LIM_W   = $clog2(COORD_LIMIT + 1);
    localparam int CMP_W   = (LIM_W > COORD_W) ? LIM_W : COORD_W;

    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(COORD_LIMIT);

    logic [10:0] band_left_reg;
    logic [10:0] band_top_reg;
    logic [7:0]  key_width_reg;
    logic [8:0]  key_height_reg;
    logic [7:0]  diff_thr_reg;
    logic [3:0]  confirm_reg;

    logic [SPAN_W-1:0] bl5_reg, blw_reg, bl2w_reg, bl3w_reg, bl4w_reg, bl5w_reg;
    logic [SPAN_W-1:0] top5_reg, top_kh_reg;
    logic [HIT_W-1:0]  area_reg;

    logic              v1_reg;
    logic [7:0]        gray_reg, bkg_reg, cr_reg, cb_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic              last1_reg;

    logic              v2_reg;
    logic [KEYS-1:0]   inc_reg;
    logic              last2_reg;

    logic [HIT_W-1:0]  hit_cnt_reg  [KEYS];
    logic [VOTE_W-1:0] vote_cnt_reg [KEYS];

    logic              m_tvalid_reg;
    logic [2:0]        m_hit_key_reg;
    logic              m_note_valid_reg;
    logic [1:0]        m_note_key_reg;

    logic              advance;
    logic              fire;

    logic [7:0]        diff;
    logic              skin, fg, coord_ok, row_in;
    logic [SPAN_W-1:0] col_w, row_w;
    logic [KEYS-1:0]   inc_next;

    logic [HIT_W-1:0]  hit_cnt_next  [KEYS];
    logic [VOTE_W-1:0] vote_cnt_next [KEYS];
    logic [VOTE_W-1:0] vote_inc      [KEYS];
    logic [KEYS-1:0]   key_hit;
    logic [PROD_W-1:0] prod          [KEYS];
    logic [VOTE_W-1:0] need;
    krhv_pkg::hit_code_t hit_code;
    logic [1:0]        hit_idx;
    logic              hit_any;
    logic              note_valid;
    logic [1:0]        note_key;

    assign advance  = !(v2_reg && last2_reg && m_tvalid_reg && !m_tready);
    assign fire     = advance && v2_reg;
    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_note_key_reg, m_note_valid_reg, m_hit_key_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_left_reg  <= 11'd1007;
            band_top_reg   <= 11'd357;
            key_width_reg  <= 8'd69;
            key_height_reg <= 9'd250;
            diff_thr_reg   <= 8'd50;
            confirm_reg    <= 4'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                krhv_pkg::CFG_BAND_LEFT:  band_left_reg  <= cfg_wdata;
                krhv_pkg::CFG_BAND_TOP:   band_top_reg   <= cfg_wdata;
                krhv_pkg::CFG_KEY_WIDTH:  key_width_reg  <= cfg_wdata[7:0];
                krhv_pkg::CFG_KEY_HEIGHT: key_height_reg <= cfg_wdata[8:0];
                krhv_pkg::CFG_DIFF_THR:   diff_thr_reg   <= cfg_wdata[7:0];
                krhv_pkg::CFG_CONFIRM:    confirm_reg    <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        bl5_reg    <= SPAN_W'(band_left_reg) + krhv_pkg::C_INSET;
        blw_reg    <= SPAN_W'(band_left_reg) + SPAN_W'(key_width_reg);
        bl2w_reg   <= SPAN_W'(band_left_reg) + SPAN_W'({key_width_reg, 1'b0});
        bl3w_reg   <= SPAN_W'(band_left_reg) + SPAN_W'({key_width_reg, 1'b0})
                      + SPAN_W'(key_width_reg);
        bl4w_reg   <= SPAN_W'(band_left_reg) + SPAN_W'({key_width_reg, 2'b00});
        bl5w_reg   <= SPAN_W'(band_left_reg) + SPAN_W'({key_width_reg, 2'b00})
                      + SPAN_W'(key_width_reg);
        top5_reg   <= SPAN_W'(band_top_reg) + krhv_pkg::C_INSET;
        top_kh_reg <= SPAN_W'(band_top_reg) + SPAN_W'(key_height_reg);
        area_reg   <= HIT_W'(key_width_reg * key_height_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gray_reg  <= s_tdata[7:0];
            bkg_reg   <= s_tdata[15:8];
            cr_reg    <= s_tdata[23:16];
            cb_reg    <= s_tdata[31:24];
            col_reg   <= s_tdata[42:32];
            row_reg   <= s_tdata[53:43];
            last1_reg <= s_tlast;
            inc_reg   <= inc_next;
            last2_reg <= last1_reg;
        end
    end

    always_comb begin
        diff = (gray_reg > bkg_reg) ? gray_reg - bkg_reg : bkg_reg - gray_reg;
        skin = cr_reg >= krhv_pkg::SKIN_CR_LO && cr_reg <= krhv_pkg::SKIN_CR_HI
            && cb_reg >= krhv_pkg::SKIN_CB_LO && cb_reg <= krhv_pkg::SKIN_CB_HI;
        fg = diff > diff_thr_reg && !skin;
        coord_ok = CMP_W'(col_reg) < LIMIT && CMP_W'(row_reg) < LIMIT;
        col_w = SPAN_W'(col_reg);
        row_w = SPAN_W'(row_reg);
        row_in = row_reg >= band_top_reg && row_w < top_kh_reg;
        inc_next = '0;
        if (fg && coord_ok && row_in) begin
            inc_next[krhv_pkg::KEY_C] = col_w >= bl5_reg
                && col_w + krhv_pkg::C_INSET < blw_reg
                && row_w >= top5_reg && row_w + krhv_pkg::C_INSET < top_kh_reg;
            inc_next[krhv_pkg::KEY_D] = col_w >= blw_reg && col_w < bl2w_reg;
            inc_next[krhv_pkg::KEY_E] = col_w >= bl2w_reg && col_w < bl3w_reg;
            inc_next[krhv_pkg::KEY_G] = col_w >= bl4w_reg && col_w < bl5w_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            if (inc_reg[k] && hit_cnt_reg[k] != krhv_pkg::HIT_MAX) begin
                hit_cnt_next[k] = hit_cnt_reg[k] + HIT_W'(1);
            end else begin
                hit_cnt_next[k] = hit_cnt_reg[k];
            end
            // count >= area / div holds exactly when area < div * (count + 1).
            prod[k] = PROD_W'(krhv_pkg::KEY_DIV[k])
                      * (PROD_W'(hit_cnt_next[k]) + PROD_W'(1));
            key_hit[k] = PROD_W'(area_reg) < prod[k];
        end

        hit_any  = 1'b1;
        hit_idx  = krhv_pkg::KEY_C;
        hit_code = krhv_pkg::HIT_NONE;
        priority if (key_hit[krhv_pkg::KEY_E]) begin
            hit_idx  = krhv_pkg::KEY_E;
            hit_code = krhv_pkg::HIT_E;
        end else if (key_hit[krhv_pkg::KEY_D]) begin
            hit_idx  = krhv_pkg::KEY_D;
            hit_code = krhv_pkg::HIT_D;
        end else if (key_hit[krhv_pkg::KEY_C]) begin
            hit_idx  = krhv_pkg::KEY_C;
            hit_code = krhv_pkg::HIT_C;
        end else if (key_hit[krhv_pkg::KEY_G]) begin
            hit_idx  = krhv_pkg::KEY_G;
            hit_code = krhv_pkg::HIT_G;
        end else begin
            hit_any = 1'b0;
        end

        for (int k = 0; k < KEYS; k++) begin
            if (hit_any && hit_idx == 2'(k) && vote_cnt_reg[k] != krhv_pkg::VOTE_MAX) begin
                vote_inc[k] = vote_cnt_reg[k] + VOTE_W'(1);
            end else begin
                vote_inc[k] = vote_cnt_reg[k];
            end
        end

        need = (confirm_reg == '0) ? VOTE_W'(1) : confirm_reg;
        note_valid = 1'b1;
        note_key   = krhv_pkg::KEY_C;
        priority if (vote_inc[krhv_pkg::KEY_C] >= need) begin
            note_key = krhv_pkg::KEY_C;
        end else if (vote_inc[krhv_pkg::KEY_D] >= need) begin
            note_key = krhv_pkg::KEY_D;
        end else if (vote_inc[krhv_pkg::KEY_E] >= need) begin
            note_key = krhv_pkg::KEY_E;
        end else if (vote_inc[krhv_pkg::KEY_G] >= need) begin
            note_key = krhv_pkg::KEY_G;
        end else begin
            note_valid = 1'b0;
        end

        for (int k = 0; k < KEYS; k++) begin
            vote_cnt_next[k] = note_valid ? '0 : vote_inc[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEYS; k++) begin
                hit_cnt_reg[k]  <= '0;
                vote_cnt_reg[k] <= '0;
            end
        end else if (fire) begin
            for (int k = 0; k < KEYS; k++) begin
                hit_cnt_reg[k] <= last2_reg ? '0 : hit_cnt_next[k];
                if (last2_reg) begin
                    vote_cnt_reg[k] <= vote_cnt_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire && last2_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && last2_reg) begin
            m_hit_key_reg    <= hit_code;
            m_note_valid_reg <= note_valid;
            m_note_key_reg   <= note_valid ? note_key : krhv_pkg::KEY_C;
        end
    end

    `ASSERT_NEXT(a_hits_clear_at_frame_end, fire && last2_reg,
        hit_cnt_reg[0] == '0 && hit_cnt_reg[1] == '0 && hit_cnt_reg[2] == '0
        && hit_cnt_reg[3] == '0, "hit counts not cleared after frame end")
    `ASSERT_NEXT(a_votes_clear_on_note, fire && last2_reg && note_valid,
        vote_cnt_reg[0] == '0 && vote_cnt_reg[1] == '0 && vote_cnt_reg[2] == '0
        && vote_cnt_reg[3] == '0, "votes not cleared after a note")
    `ASSERT_NEXT(a_result_word_from_frame_end, !m_tvalid_reg && !(fire && last2_reg),
        !m_tvalid_reg, "result word appeared without a frame-end pixel")
    `ASSERT_CLK(a_note_key_zero_without_note, m_tvalid_reg && !m_note_valid_reg
        |-> m_note_key_reg == krhv_pkg::KEY_C, "note key set without a note")

endmodule
